/* src/rme_pkg.sv */
// shared types and constants for the modular exponentiation core
// no dependencies

package rme_pkg;

    // default word width of the arithmetic
    localparam int WORD_BITS_DEF = 32;

    // fixed field widths of the ports
    localparam int DATA_W      = 32;
    localparam int CFG_INDEX_W = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = 1'd1;

    // register values after reset
    localparam logic [DATA_W-1:0] MODULUS_RESET  = 32'd3233;
    localparam logic [DATA_W-1:0] EXPONENT_RESET = 32'd17;

    // status of the serial modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

/* src/rme_modmul.sv */
// bit-serial modular multiplier: result = a * b mod m, one bit of b per cycle
// depends on rme_pkg; needs a < m at start

module rme_modmul #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic [WORD_BITS-1:0] m,
    output logic [WORD_BITS-1:0] result,
    output rme_pkg::mm_stat_t    stat
);
    import rme_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int SUM_W = WORD_BITS + 2;

    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m1;
    logic [SUM_W-1:0] m2;
    logic [SUM_W-1:0] d1;
    logic [SUM_W-1:0] d2;
    logic [WORD_BITS-1:0] r_step;

    // 2r + a stays below 3m, so at most 2m comes off
    always_comb
    begin
        sum = {1'b0, r_reg, 1'b0} + (b_reg[WORD_BITS-1] ? {2'b00, a} : '0);
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        d1  = sum - m1;
        d2  = sum - m2;
        if (sum >= m2)
        begin
            r_step = d2[WORD_BITS-1:0];
        end
        else if (sum >= m1)
        begin
            r_step = d1[WORD_BITS-1:0];
        end
        else
        begin
            r_step = sum[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            r_next    = '0;
            b_next    = b;
            cnt_next  = CNT_W'(WORD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = r_step;
            b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign result    = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("multiplier did not go busy after start");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == '0 |=> done_reg && !busy_reg)
        else $error("multiplier missed its last step");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");
`endif

endmodule

/* src/rsa_modular_exponentiation_core.sv */
// top level of the modular exponentiation core: config registers and sequencer
// depends on rme_pkg and rme_modmul

// Raises each message word to the exponent register, modulo the modulus register,
// by right-to-left square-and-multiply; one item is in work at a time. Every
// modular product goes through one bit-serial multiplier. The finished result
// moves to an output register, so a stalled result only holds off the core
// when the next result is ready before it leaves. A modulus of zero gives 0
// and an exponent of zero gives 1 mod n.

module rsa_modular_exponentiation_core #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rme_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rme_pkg::DATA_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rme_pkg::DATA_W-1:0]       message,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rme_pkg::DATA_W-1:0]       power_mod
);
    import rme_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_SQR    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [WORD_BITS-1:0] modulus_reg, modulus_next;
    logic [WORD_BITS-1:0] exponent_reg, exponent_next;
    logic [2:0]           state_reg, state_next;
    logic                 start_reg, start_next;
    logic [CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] msg_reg, msg_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] power_mod_reg, power_mod_next;

    logic [WORD_BITS-1:0] one_mod;
    logic [WORD_BITS-1:0] mul_a;
    logic [WORD_BITS-1:0] mul_b;
    logic [WORD_BITS-1:0] mul_result;
    mm_stat_t             mul_stat;
    logic                 cur_last;
    logic                 nxt_last;
    logic                 in_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign one_mod  = (modulus_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
    assign cur_last = bit_cnt_reg == CNT_W'(WORD_BITS - 1);
    assign nxt_last = bit_cnt_reg == CNT_W'(WORD_BITS - 2);

    // config writes
    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_we && cfg_index == CFG_MODULUS)
        begin
            modulus_next = cfg_data[WORD_BITS-1:0];
        end
        if (cfg_we && cfg_index == CFG_EXPONENT)
        begin
            exponent_next = cfg_data[WORD_BITS-1:0];
        end
    end

    // multiplier operands follow the state
    always_comb
    begin
        case (state_reg)
            S_REDUCE:
            begin
                mul_a = one_mod;
                mul_b = msg_reg;
            end
            S_MUL:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        bit_cnt_next   = bit_cnt_reg;
        exp_next       = exp_reg;
        msg_next       = msg_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && out_stall;
        power_mod_next = power_mod_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    msg_next     = message[WORD_BITS-1:0];
                    acc_next     = one_mod;
                    exp_next     = exponent_reg;
                    bit_cnt_next = '0;
                    start_next   = 1'b1;
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (mul_stat.done)
                begin
                    base_next = mul_result;
                    if (exp_reg[0])
                    begin
                        state_next = S_MUL;
                        start_next = 1'b1;
                    end
                    else if (cur_last)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SQR;
                        start_next = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_result;
                    if (cur_last)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SQR;
                        start_next = 1'b1;
                    end
                end
            end
            S_SQR:
            begin
                if (mul_stat.done)
                begin
                    base_next    = mul_result;
                    exp_next     = {1'b0, exp_reg[WORD_BITS-1:1]};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    // no square after the top exponent bit
                    if (exp_reg[1])
                    begin
                        state_next = S_MUL;
                        start_next = 1'b1;
                    end
                    else if (nxt_last)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SQR;
                        start_next = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                // wait here only while the previous result is still stalled
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    power_mod_next = (modulus_reg == '0) ? '0 : acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET[WORD_BITS-1:0];
            exponent_reg  <= EXPONENT_RESET[WORD_BITS-1:0];
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            state_reg     <= state_next;
            start_reg     <= start_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg       <= exp_next;
        msg_reg       <= msg_next;
        acc_reg       <= acc_next;
        base_reg      <= base_next;
        power_mod_reg <= power_mod_next;
    end

    rme_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .a      (mul_a),
        .b      (mul_b),
        .m      (modulus_reg),
        .result (mul_result),
        .stat   (mul_stat)
    );

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign power_mod = DATA_W'(power_mod_reg);

`ifndef SYNTHESIS
    a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> state_reg == S_REDUCE || state_reg == S_MUL
                          || state_reg == S_SQR)
        else $error("multiplier finished outside a work state");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(power_mod))
        else $error("stalled result changed");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && state_reg != S_OUT |=> !out_valid)
        else $error("result repeated after output transfer");
`endif

endmodule

/* tb/sv/rsa_modular_exponentiation_core_tb.sv */
// testbench for the modular exponentiation core: directed table, then random phases
// depends on rme_pkg and rsa_modular_exponentiation_core

module rsa_modular_exponentiation_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rme_pkg::*;

    localparam int WB = WORD_BITS_DEF;
    localparam logic [63:0] WORD_MASK = (64'd1 << WB) - 64'd1;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 2200;
    localparam int RANDOM_ITEMS = 270;
    localparam int MAX_REPORTS = 10;
    localparam int TIME_LIMIT_NS = 40_000_000;
    localparam int DIR_N = 22;

    typedef struct packed {
        logic        wr;
        logic [31:0] n;
        logic [31:0] e;
        logic [31:0] msg;
        logic        known;
        logic [31:0] want;
    } dir_row_t;

    // wr loads n and e before the transfer; known rows carry their result
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{1'b0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0},
        '{1'b0, 32'd0, 32'd0, 32'd1, 1'b1, 32'd1},
        '{1'b0, 32'd0, 32'd0, 32'd65, 1'b1, 32'd2790},
        '{1'b0, 32'd0, 32'd0, 32'd3233, 1'b1, 32'd0},
        '{1'b0, 32'd0, 32'd0, 32'd3298, 1'b1, 32'd2790},
        '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{1'b1, 32'd3233, 32'd2753, 32'd2790, 1'b1, 32'd65},
        '{1'b0, 32'd0, 32'd0, 32'h8000_0000, 1'b0, 32'd0},
        '{1'b1, 32'd3233, 32'd0, 32'd12345, 1'b1, 32'd1},
        '{1'b0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd1},
        '{1'b1, 32'd1, 32'd0, 32'd5, 1'b1, 32'd0},
        '{1'b1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{1'b1, 32'd0, 32'd17, 32'd65, 1'b1, 32'd0},
        '{1'b1, 32'd0, 32'd0, 32'd7, 1'b1, 32'd0},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'd0},
        '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{1'b0, 32'd0, 32'd0, 32'd2, 1'b0, 32'd0},
        '{1'b1, 32'd2, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd1},
        '{1'b1, 32'h8000_0000, 32'h8000_0000, 32'd3, 1'b0, 32'd0},
        '{1'b1, 32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'd2, 1'b0, 32'd0},
        '{1'b1, 32'hFFFF_FFFB, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd4},
        '{1'b1, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'd0}
    };

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MODULUS;
    logic [DATA_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [DATA_W-1:0]      message = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [DATA_W-1:0]      power_mod;

    rsa_modular_exponentiation_core #(
        .WORD_BITS(WB)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .message(message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .power_mod(power_mod)
    );

    logic [63:0] cur_modulus;
    logic [63:0] cur_exponent;
    logic [31:0] pending_power [$];
    logic [31:0] oldest_power;
    int          fails = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    int          settings_used = 0;
    bit          burst_phase = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIME_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // right-to-left square and multiply under the current register copies
    function automatic logic [31:0] predict_power(input logic [63:0] word);
        logic [63:0] acc;
        logic [63:0] base;
        if (cur_modulus == 64'd0)
            return 32'd0;
        acc  = 64'd1 % cur_modulus;
        base = word % cur_modulus;
        for (int i = 0; i < WB; i++)
        begin
            if (cur_exponent[i])
                acc = (acc * base) % cur_modulus;
            base = (base * base) % cur_modulus;
        end
        return acc[31:0];
    endfunction

    task automatic report_fail(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_power.size() == 0)
                report_fail("result with nothing pending", 32'hx, power_mod);
            else
            begin
                oldest_power = pending_power.pop_front();
                results_checked++;
                if (power_mod !== oldest_power)
                    report_fail("power_mod", oldest_power, power_mod);
            end
        end
    end

    // receiver: short stall runs, a few long ones, and long stretches without stalls
    initial
    begin
        int quiet;
        int hold;
        forever
        begin
            quiet = ($urandom_range(5) == 0) ? $urandom_range(3000, 200)
                                             : $urandom_range(8, 0);
            hold  = ($urandom_range(7) == 0) ? $urandom_range(80, 20)
                                             : $urandom_range(4, 1);
            repeat (quiet) @(negedge clk) out_stall <= 1'b0;
            repeat (hold) @(negedge clk) out_stall <= 1'b1;
        end
    end

    task automatic drain_pending();
        @(negedge clk) in_valid <= 1'b0;
        while (pending_power.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_config(input logic [31:0] n, input logic [31:0] e);
        drain_pending();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODULUS;
        cfg_data  <= n;
        @(negedge clk);
        cfg_index <= CFG_EXPONENT;
        cfg_data  <= e;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_modulus  = {32'd0, n} & WORD_MASK;
        cur_exponent = {32'd0, e} & WORD_MASK;
        settings_used++;
    endtask

    // holds the word until the transfer, then queues what it must produce
    task automatic send_word(input logic [31:0] word, input bit known,
                             input logic [31:0] want);
        logic [31:0] predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        message  <= word;
        predicted = known ? want : predict_power({32'd0, word} & WORD_MASK);
        do
            @(posedge clk);
        while (in_stall);
        pending_power.push_back(predicted);
        words_sent++;
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_phase)
            return 0;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(2, 0);
        if (r < 90)
            return $urandom_range(10, 3);
        return $urandom_range(60, 20);
    endfunction

    task automatic pause_gap(input int gap);
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_modulus();
        int r;
        r = $urandom_range(11);
        case (r)
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom_range(4000, 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_exponent();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(70, 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_message();
        logic [31:0] n;
        int r;
        n = cur_modulus[31:0];
        r = $urandom_range(9);
        case (r)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return n - 32'd1;
            3: return n;
            4: return n + 32'd1;
            5, 6: return (n == 32'd0) ? $urandom : $urandom_range(n - 32'd1, 0);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int random_sent;
        int phase_len;
        random_sent  = 0;
        cur_modulus  = {32'd0, MODULUS_RESET} & WORD_MASK;
        cur_exponent = {32'd0, EXPONENT_RESET} & WORD_MASK;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_ROWS[i].wr)
                load_config(DIR_ROWS[i].n, DIR_ROWS[i].e);
            send_word(DIR_ROWS[i].msg, DIR_ROWS[i].known, DIR_ROWS[i].want);
            pause_gap(pick_gap());
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            load_config(pick_modulus(), pick_exponent());
            burst_phase = ($urandom_range(2) == 0);
            phase_len = $urandom_range(30, 10);
            for (int k = 0; k < phase_len; k++)
            begin
                send_word(pick_message(), 1'b0, 32'd0);
                random_sent++;
                // now and then let the core run dry before the next transfer
                if ($urandom_range(24) == 0)
                    drain_pending();
                else
                    pause_gap(pick_gap());
            end
        end

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);
        fails += pending_power.size();

        $display("run covered %0d words under %0d register settings, %0d results checked",
                 words_sent, settings_used, results_checked);
        $display("settings took in zero and unit modulus, zero and all-ones exponent");
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/rme_pkg.sv
src/rme_modmul.sv
src/rsa_modular_exponentiation_core.sv
tb/sv/rsa_modular_exponentiation_core_tb.sv
